// ===== src/brfr_pkg.sv =====
// Shared types and constants for the bitmap rectangle fill and rotate block.
// Depends on nothing; used by the bitmap store, the dump sequencer and the top level.
package brfr_pkg;

    localparam int DEF_WIDTH  = 64;
    localparam int DEF_HEIGHT = 8;

    localparam int CMD_W      = 2;
    localparam int ARG_W      = 8;
    localparam int ROW_BITS_W = 64;
    localparam int NUM_W      = 3;
    localparam int TOTAL_W    = 10;
    localparam int SHIFT_W    = 6;
    localparam int ARG_CODES  = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL = 2'd0,
        CMD_ROW  = 2'd1,
        CMD_COL  = 2'd2,
        CMD_DUMP = 2'd3
    } t_cmd;

    // One update for the bitmap store.
    typedef struct packed {
        logic             en;
        t_cmd             cmd;
        logic [ARG_W-1:0] arg_first;
        logic [ARG_W-1:0] arg_second;
    } t_upd;

    typedef logic [SHIFT_W-1:0] t_mod_tab [ARG_CODES];

    // Table of n modulo m for every 8-bit n, built at elaboration by counting.
    function automatic t_mod_tab mod_table(input int m);
        t_mod_tab tab;
        int       r;
        r = 0;
        for (int i = 0; i < ARG_CODES; i++) begin
            tab[i] = SHIFT_W'(r);
            r = r + 1;
            if (r == m) begin
                r = 0;
            end
        end
        return tab;
    endfunction

endpackage

// ===== src/brfr_bitmap.sv =====
// Bitmap store: HEIGHT rows of WIDTH pixels with fill, row rotate and column rotate.
// Depends on brfr_pkg for the command codes, the update struct and the shift tables.
module brfr_bitmap #(
    parameter int WIDTH  = brfr_pkg::DEF_WIDTH,
    parameter int HEIGHT = brfr_pkg::DEF_HEIGHT,
    parameter int ROW_W  = (HEIGHT > 1) ? $clog2(HEIGHT) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brfr_pkg::t_upd    i_upd,
    input  logic [ROW_W-1:0]  i_rd_idx,
    output logic [WIDTH-1:0]  o_rd_row
);
    import brfr_pkg::*;

    localparam int COL_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam t_mod_tab W_MOD = mod_table(WIDTH);
    localparam t_mod_tab H_MOD = mod_table(HEIGHT);

    logic [WIDTH-1:0]    r_rows [HEIGHT];
    logic [WIDTH-1:0]    n_rows [HEIGHT];

    logic [WIDTH-1:0]    fill_mask;
    logic [2*WIDTH-1:0]  row_dbl;
    logic [WIDTH-1:0]    row_rot;
    logic [HEIGHT-1:0]   col_v;
    logic [2*HEIGHT-1:0] col_dbl;
    logic [HEIGHT-1:0]   col_rot;
    logic [ROW_W-1:0]    row_idx;
    logic [COL_W-1:0]    col_idx;
    logic [SHIFT_W-1:0]  w_shift;
    logic [SHIFT_W-1:0]  h_shift;

    assign row_idx  = i_upd.arg_first[ROW_W-1:0];
    assign col_idx  = i_upd.arg_first[COL_W-1:0];
    assign w_shift  = W_MOD[i_upd.arg_second];
    assign h_shift  = H_MOD[i_upd.arg_second];
    assign o_rd_row = r_rows[i_rd_idx];

    always_comb begin
        for (int x = 0; x < WIDTH; x++) begin
            fill_mask[x] = i_upd.arg_first > ARG_W'(x);
        end
        // Shifting the doubled word left and taking its upper half moves bit i to i + shift.
        row_dbl = {r_rows[row_idx], r_rows[row_idx]} << w_shift;
        row_rot = row_dbl[2*WIDTH-1:WIDTH];
        for (int y = 0; y < HEIGHT; y++) begin
            col_v[y] = r_rows[y][col_idx];
        end
        col_dbl = {col_v, col_v} << h_shift;
        col_rot = col_dbl[2*HEIGHT-1:HEIGHT];
    end

    always_comb begin
        n_rows = r_rows;
        if (i_upd.en) begin
            unique case (i_upd.cmd)
                CMD_FILL: begin
                    for (int y = 0; y < HEIGHT; y++) begin
                        if (i_upd.arg_second > ARG_W'(y)) begin
                            n_rows[y] = r_rows[y] | fill_mask;
                        end
                    end
                end
                CMD_ROW: begin
                    if (i_upd.arg_first < ARG_W'(HEIGHT)) begin
                        n_rows[row_idx] = row_rot;
                    end
                end
                CMD_COL: begin
                    if (i_upd.arg_first < ARG_W'(WIDTH)) begin
                        for (int y = 0; y < HEIGHT; y++) begin
                            n_rows[y][col_idx] = col_rot[y];
                        end
                    end
                end
                CMD_DUMP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < HEIGHT; y++) begin
                r_rows[y] <= '0;
            end
        end else begin
            r_rows <= n_rows;
        end
    end

endmodule

// ===== src/brfr_dump.sv =====
// Dump sequencer: counts the lit pixels one row a cycle, then emits every row.
// Depends on brfr_pkg for the result field widths; reads rows from brfr_bitmap.
module brfr_dump #(
    parameter int WIDTH  = brfr_pkg::DEF_WIDTH,
    parameter int HEIGHT = brfr_pkg::DEF_HEIGHT,
    parameter int ROW_W  = (HEIGHT > 1) ? $clog2(HEIGHT) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    output logic [ROW_W-1:0]                o_rd_idx,
    input  logic [WIDTH-1:0]                i_rd_row,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [brfr_pkg::ROW_BITS_W-1:0] o_row_bits,
    output logic [brfr_pkg::NUM_W-1:0]      o_row_number,
    output logic                            o_last_row,
    output logic [brfr_pkg::TOTAL_W-1:0]    o_lit_total
);
    import brfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_COUNT = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_vld, n_vld;
    logic [ROW_BITS_W-1:0] r_bits;
    logic [NUM_W-1:0]    r_num;
    logic                r_last;
    logic [TOTAL_W-1:0]  r_out_total;

    logic at_last;
    logic load;

    assign at_last  = r_row == ROW_W'(HEIGHT - 1);
    assign load     = (r_state == S_EMIT) && (!r_vld || !i_stall);
    assign o_busy   = r_state != S_IDLE;
    assign o_rd_idx = r_row;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_total = r_total;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_COUNT;
                    n_row   = '0;
                    n_total = '0;
                end
            end
            S_COUNT: begin
                n_total = r_total + TOTAL_W'($countones(i_rd_row));
                if (at_last) begin
                    n_state = S_EMIT;
                    n_row   = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            S_EMIT: begin
                if (load) begin
                    if (at_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            n_vld = 1'b1;
        end else if (!i_stall) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_total <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_total <= n_total;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bits      <= ROW_BITS_W'(i_rd_row);
            r_num       <= NUM_W'(r_row);
            r_last      <= at_last;
            r_out_total <= r_total;
        end
    end

    assign o_valid      = r_vld;
    assign o_row_bits   = r_bits;
    assign o_row_number = r_num;
    assign o_last_row   = r_last;
    assign o_lit_total  = r_out_total;

endmodule

// ===== src/bitmap_rect_fill_and_rotate_top.sv =====
// Top level of the bitmap rectangle fill and rotate block.
// Depends on brfr_pkg, brfr_bitmap and brfr_dump.
//
// The block keeps a monochrome bitmap of HEIGHT rows by WIDTH columns.
// Commands arrive on the input channel (i_valid, o_stall, i_command,
// i_arg_first, i_arg_second); a transaction completes at a rising edge
// where i_valid is high and o_stall is low. Each command is first taken
// into an input register. A fill, row rotate or column rotate is applied
// to the bitmap from that register by one pass of mask and barrel rotator
// logic, so such commands sustain one transaction per cycle while no dump
// is in progress. A dump produces HEIGHT row transactions on the output
// channel (o_valid, i_stall and the result fields). The dump sequencer
// first adds up the lit pixels one row per cycle, then emits one row per
// cycle through an output register while the receiver does not stall.
// Later commands wait in the input register while a dump is in progress,
// which raises o_stall. When the receiver raises i_stall the current row
// is held unchanged and emission pauses. Reset clears every pixel to dark
// and empties the input and output registers.
module bitmap_rect_fill_and_rotate_top #(
    parameter int WIDTH  = brfr_pkg::DEF_WIDTH,
    parameter int HEIGHT = brfr_pkg::DEF_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [brfr_pkg::CMD_W-1:0]      i_command,
    input  logic [brfr_pkg::ARG_W-1:0]      i_arg_first,
    input  logic [brfr_pkg::ARG_W-1:0]      i_arg_second,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [brfr_pkg::ROW_BITS_W-1:0] o_row_bits,
    output logic [brfr_pkg::NUM_W-1:0]      o_row_number,
    output logic                            o_last_row,
    output logic [brfr_pkg::TOTAL_W-1:0]    o_lit_total
);
    import brfr_pkg::*;

    localparam int ROW_W = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

    // Input register.
    logic             r_in_vld, n_in_vld;
    t_cmd             r_cmd;
    logic [ARG_W-1:0] r_arg_first;
    logic [ARG_W-1:0] r_arg_second;

    logic             accept;
    logic             consume;
    logic             dump_busy;
    t_upd             upd;
    logic             dump_start;
    logic [ROW_W-1:0] rd_idx;
    logic [WIDTH-1:0] rd_row;

    // The held command moves on whenever no dump is in progress; the bitmap
    // must stay still while a dump is reading it.
    assign consume = r_in_vld && !dump_busy;
    assign o_stall = r_in_vld && dump_busy;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (consume) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= t_cmd'(i_command);
            r_arg_first  <= i_arg_first;
            r_arg_second <= i_arg_second;
        end
    end

    assign dump_start     = consume && (r_cmd == CMD_DUMP);
    assign upd.en         = consume && (r_cmd != CMD_DUMP);
    assign upd.cmd        = r_cmd;
    assign upd.arg_first  = r_arg_first;
    assign upd.arg_second = r_arg_second;

    brfr_bitmap #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .ROW_W  (ROW_W)
    ) u_bitmap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (upd),
        .i_rd_idx (rd_idx),
        .o_rd_row (rd_row)
    );

    brfr_dump #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .ROW_W  (ROW_W)
    ) u_dump (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (dump_start),
        .o_busy       (dump_busy),
        .o_rd_idx     (rd_idx),
        .i_rd_row     (rd_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_bits   (o_row_bits),
        .o_row_number (o_row_number),
        .o_last_row   (o_last_row),
        .o_lit_total  (o_lit_total)
    );

endmodule

// ===== dv/brfr_checker.sv =====
// Scoreboard for the bitmap rectangle fill and rotate block: it keeps its own copy of the
// bitmap, predicts the rows of every dump and compares each row transaction as it leaves.
// Depends on brfr_pkg for the command codes and field widths.
module brfr_checker #(
    parameter int WIDTH  = brfr_pkg::DEF_WIDTH,
    parameter int HEIGHT = brfr_pkg::DEF_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_stall,
    input  logic [brfr_pkg::CMD_W-1:0]      i_command,
    input  logic [brfr_pkg::ARG_W-1:0]      i_arg_first,
    input  logic [brfr_pkg::ARG_W-1:0]      i_arg_second,
    input  logic                            i_row_valid,
    input  logic                            i_row_stall,
    input  logic [brfr_pkg::ROW_BITS_W-1:0] i_row_bits,
    input  logic [brfr_pkg::NUM_W-1:0]      i_row_number,
    input  logic                            i_last_row,
    input  logic [brfr_pkg::TOTAL_W-1:0]    i_lit_total,
    output int                              o_fail_count,
    output int                              o_rows_pending,
    output int                              o_rows_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import brfr_pkg::*;

    localparam logic [ROW_BITS_W-1:0] ROW_MASK =
        (WIDTH >= ROW_BITS_W) ? {ROW_BITS_W{1'b1}} : ((64'd1 << WIDTH) - 64'd1);

    typedef struct {
        logic [ROW_BITS_W-1:0] bits;
        logic [NUM_W-1:0]      num;
        logic                  last;
        logic [TOTAL_W-1:0]    total;
    } t_dump_row;

    logic [ROW_BITS_W-1:0] screen [HEIGHT];
    t_dump_row             dump_rows_due [$];
    int                    fails;
    int                    rows_checked;

    initial begin
        fails        = 0;
        rows_checked = 0;
        o_fail_count   = 0;
        o_rows_pending = 0;
        o_rows_checked = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: row mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fails++;
    endtask

    function automatic void light_corner(input int w, input int h);
        int                    cw;
        int                    ch;
        logic [ROW_BITS_W-1:0] mask;
        cw = (w > WIDTH) ? WIDTH : w;
        ch = (h > HEIGHT) ? HEIGHT : h;
        mask = (cw >= ROW_BITS_W) ? {ROW_BITS_W{1'b1}} : ((64'd1 << cw) - 64'd1);
        mask &= ROW_MASK;
        for (int y = 0; y < ch; y++) begin
            screen[y] |= mask;
        end
    endfunction

    // Right rotation: pixel x moves to column (x + shift) mod WIDTH.
    function automatic void spin_row(input int r, input int s);
        int                    sh;
        logic [ROW_BITS_W-1:0] res;
        if (r < HEIGHT) begin
            sh  = s % WIDTH;
            res = '0;
            for (int i = 0; i < WIDTH; i++) begin
                if (screen[r][i]) begin
                    res[(i + sh) % WIDTH] = 1'b1;
                end
            end
            screen[r] = res & ROW_MASK;
        end
    endfunction

    // Downward rotation: the pixel of row y moves to row (y + shift) mod HEIGHT.
    function automatic void spin_column(input int c, input int s);
        int   sh;
        logic col [HEIGHT];
        if (c < WIDTH) begin
            sh = s % HEIGHT;
            for (int i = 0; i < HEIGHT; i++) begin
                col[(i + sh) % HEIGHT] = screen[i][c];
            end
            for (int i = 0; i < HEIGHT; i++) begin
                screen[i][c] = col[i];
            end
        end
    endfunction

    function automatic void queue_dump();
        int        lit;
        t_dump_row row;
        lit = 0;
        for (int y = 0; y < HEIGHT; y++) begin
            lit += $countones(screen[y]);
        end
        for (int y = 0; y < HEIGHT; y++) begin
            row.bits  = screen[y] & ROW_MASK;
            row.num   = NUM_W'(y);
            row.last  = (y == HEIGHT - 1);
            row.total = TOTAL_W'(lit);
            dump_rows_due.push_back(row);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_dump_row want;
        if (!i_rst_n) begin
            for (int y = 0; y < HEIGHT; y++) begin
                screen[y] = '0;
            end
            dump_rows_due.delete();
        end else begin
            if (i_cmd_valid && !i_cmd_stall) begin
                case (t_cmd'(i_command))
                    CMD_FILL: light_corner(int'(i_arg_first), int'(i_arg_second));
                    CMD_ROW:  spin_row(int'(i_arg_first), int'(i_arg_second));
                    CMD_COL:  spin_column(int'(i_arg_first), int'(i_arg_second));
                    CMD_DUMP: queue_dump();
                endcase
            end
            if (i_row_valid && !i_row_stall) begin
                if (dump_rows_due.size() == 0) begin
                    report_mismatch("a row with no dump outstanding", 64'(i_row_number), 64'hx);
                end else begin
                    want = dump_rows_due.pop_front();
                    if (i_row_bits !== want.bits) begin
                        report_mismatch("row_bits", i_row_bits, want.bits);
                    end
                    if (i_row_number !== want.num) begin
                        report_mismatch("row_number", 64'(i_row_number), 64'(want.num));
                    end
                    if (i_last_row !== want.last) begin
                        report_mismatch("last_row", 64'(i_last_row), 64'(want.last));
                    end
                    if (i_lit_total !== want.total) begin
                        report_mismatch("lit_total", 64'(i_lit_total), 64'(want.total));
                    end
                    rows_checked++;
                end
            end
        end
        o_fail_count   <= fails;
        o_rows_pending <= dump_rows_due.size();
        o_rows_checked <= rows_checked;
    end

endmodule

// ===== dv/bitmap_rect_fill_and_rotate_top_tb.sv =====
// Testbench top for the bitmap rectangle fill and rotate block: clock, reset, command
// stimulus, a row sink with random back-pressure, a watchdog and the final verdict.
// Depends on brfr_pkg, the block itself and brfr_checker, which does all the checking.
module bitmap_rect_fill_and_rotate_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brfr_pkg::*;

    localparam int WIDTH          = DEF_WIDTH;
    localparam int HEIGHT         = DEF_HEIGHT;
    // Length of the deliberate hold-off on the row channel, in cycles.
    localparam int LONG_HOLD      = 80;
    // Cycles without any transaction on either channel before the run is abandoned.
    // The longest quiet stretch of a correct run is the long hold-off plus a dump's
    // start-up latency and a few idle cycles, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 50;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [CMD_W-1:0]      i_command;
    logic [ARG_W-1:0]      i_arg_first;
    logic [ARG_W-1:0]      i_arg_second;
    logic                  o_valid;
    logic                  i_stall;
    logic [ROW_BITS_W-1:0] o_row_bits;
    logic [NUM_W-1:0]      o_row_number;
    logic                  o_last_row;
    logic [TOTAL_W-1:0]    o_lit_total;

    int fail_count;
    int rows_pending;
    int rows_checked;

    // When calm is set, neither side idles, which gives back-to-back stretches.
    bit calm;
    // Set by the stimulus to ask the row sink for one long hold-off.
    bit long_hold_req;

    int fills_sent;
    int row_turns_sent;
    int col_turns_sent;
    int dumps_sent;

    bitmap_rect_fill_and_rotate_top #(
        .WIDTH (WIDTH),
        .HEIGHT(HEIGHT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_arg_first (i_arg_first),
        .i_arg_second(i_arg_second),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_row_bits  (o_row_bits),
        .o_row_number(o_row_number),
        .o_last_row  (o_last_row),
        .o_lit_total (o_lit_total)
    );

    brfr_checker #(
        .WIDTH (WIDTH),
        .HEIGHT(HEIGHT)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .i_cmd_stall   (o_stall),
        .i_command     (i_command),
        .i_arg_first   (i_arg_first),
        .i_arg_second  (i_arg_second),
        .i_row_valid   (o_valid),
        .i_row_stall   (i_stall),
        .i_row_bits    (o_row_bits),
        .i_row_number  (o_row_number),
        .i_last_row    (o_last_row),
        .i_lit_total   (o_lit_total),
        .o_fail_count  (fail_count),
        .o_rows_pending(rows_pending),
        .o_rows_checked(rows_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle cycles drawn afresh for every transaction on either side.
    function automatic int pick_gap();
        return calm ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Offers one command and returns at the edge on which the transaction completes.
    // The payload is held unchanged for as long as the block stalls it, and valid is
    // only lowered when an idle gap has been drawn, so it never drops and rises in
    // the same time step.
    task automatic send_cmd(input t_cmd c, input int a, input int b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= c;
        i_arg_first  <= ARG_W'(a);
        i_arg_second <= ARG_W'(b);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        case (c)
            CMD_FILL: fills_sent++;
            CMD_ROW:  row_turns_sent++;
            CMD_COL:  col_turns_sent++;
            CMD_DUMP: dumps_sent++;
        endcase
    endtask

    // Row sink. After every row transaction it draws how long to stall before the
    // next one; a long hold-off requested by the stimulus overrides that count, and
    // the count is kept here, cycle by cycle, whatever the sender is doing.
    initial begin : row_sink
        int stall_left;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                stall_left = pick_gap();
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: gives up once neither channel has completed a transaction for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Watchdog: no transaction for %0d cycles, %0d rows still due",
                 WATCHDOG_LIMIT, rows_pending);
        $display("FAIL bitmap_rect_fill_and_rotate_top");
        $finish;
    end

    initial begin : stimulus
        int pick;
        int a;
        int b;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_FILL;
        i_arg_first    = '0;
        i_arg_second   = '0;
        calm           = 1'b0;
        long_hold_req  = 1'b0;
        fills_sent     = 0;
        row_turns_sent = 0;
        col_turns_sent = 0;
        dumps_sent     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The screen can only be darkened by reset, so the fully lit
        // screen is left to the very end and the fills here stay modest.
        send_cmd(CMD_DUMP, 0, 0);       // freshly reset screen, all dark
        send_cmd(CMD_FILL, 0, 0);       // zero-sized rectangle lights nothing
        send_cmd(CMD_FILL, 3, 0);       // zero height
        send_cmd(CMD_FILL, 0, 4);       // zero width
        send_cmd(CMD_FILL, 3, 2);
        send_cmd(CMD_ROW, 0, 1);
        send_cmd(CMD_ROW, 1, 64);       // a full turn of a row changes nothing
        send_cmd(CMD_ROW, 1, 3);
        send_cmd(CMD_COL, 1, 1);
        send_cmd(CMD_COL, 4, 8);        // a full turn of a column changes nothing
        send_cmd(CMD_DUMP, 0, 0);
        send_cmd(CMD_ROW, 8, 5);        // rows and columns off the screen are ignored
        send_cmd(CMD_ROW, 255, 255);
        send_cmd(CMD_COL, 64, 1);
        send_cmd(CMD_COL, 255, 255);
        send_cmd(CMD_FILL, 255, 1);     // width clamped to the screen
        send_cmd(CMD_ROW, 0, 255);
        send_cmd(CMD_COL, 63, 255);
        send_cmd(CMD_FILL, 1, 255);     // height clamped to the screen
        send_cmd(CMD_COL, 0, 170);
        send_cmd(CMD_ROW, 7, 85);
        send_cmd(CMD_DUMP, 255, 255);

        // Random part, in phases that alternate between idling and back-to-back
        // traffic. Most rotations hit the screen; fills are small so that the
        // screen does not saturate, apart from degenerate ones with one size zero
        // and the other drawn over the whole 8-bit range.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm = (phase % 3 == 1);
            if (phase == 2) begin
                // Hold the row channel off while dumps keep arriving, so that the
                // block's registers fill up and it stalls the command channel.
                long_hold_req = 1'b1;
                send_cmd(CMD_DUMP, 0, 0);
                send_cmd(CMD_DUMP, 0, 0);
                send_cmd(CMD_ROW, 2, 9);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    if ($urandom_range(0, 3) == 0) begin
                        a = $urandom_range(0, 255);
                        b = 0;
                        if ($urandom_range(0, 1) == 1) begin
                            b = a;
                            a = 0;
                        end
                    end else begin
                        a = $urandom_range(0, 6);
                        b = $urandom_range(0, 3);
                    end
                    send_cmd(CMD_FILL, a, b);
                end else if (pick < 50) begin
                    a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, HEIGHT - 1);
                    send_cmd(CMD_ROW, a, $urandom_range(0, 255));
                end else if (pick < 90) begin
                    a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, WIDTH - 1);
                    send_cmd(CMD_COL, a, $urandom_range(0, 255));
                end else begin
                    send_cmd(CMD_DUMP, $urandom_range(0, 255), $urandom_range(0, 255));
                end
            end
        end

        // Closing part: light the whole screen, which takes the lit count to its top.
        calm = 1'b0;
        send_cmd(CMD_FILL, 255, 255);
        send_cmd(CMD_DUMP, 0, 0);
        send_cmd(CMD_ROW, 3, 7);
        send_cmd(CMD_COL, 9, 2);
        send_cmd(CMD_DUMP, 0, 0);
        i_valid <= 1'b0;

        // Drain: the checker's counters are registered, hence the first wait.
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
        repeat (2 * HEIGHT + 4) @(posedge i_clk);

        $display("Covered %0d fills, %0d row turns, %0d column turns and %0d dumps,",
                 fills_sent, row_turns_sent, col_turns_sent, dumps_sent);
        $display("with %0d rows compared under random idling and one long hold-off.",
                 rows_checked);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("PASS bitmap_rect_fill_and_rotate_top");
        end else begin
            $display("FAIL bitmap_rect_fill_and_rotate_top");
        end
        $finish;
    end

endmodule
